// File: src/pndd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pndd_pkg;

  localparam int DEF_ENTRIES = 224;

  localparam int COMP_W = 8;
  localparam int INDEX_W = 8;
  localparam int QDIST_W = 16;
  // three squared 8-bit differences need 18 bits
  localparam int DIST_W = 18;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [QDIST_W-1:0] NONE_DISTANCE = 16'hFFFF;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// File: src/palette_nearest_distinct_distance_unit.sv
// Palette of ENTRIES RGB colors held in one single-port memory. A load transfer
// (command 0) writes one entry in the cycle it is accepted and gives no result.
// A query transfer (command 1) reads the named entry, then walks every entry once
// through a shared distance unit (absolute differences, squares and sum, then a
// running minimum), one entry per cycle, and returns the entry's color with the
// smallest squared distance to any differing color, divided by four and floored.
// If no entry differs, none_found is set and quarter_distance is 65535.
// A query passes through the self, sweep and done states, and then its result
// goes to the output register; the memory read port takes one address per cycle.
// The input is stalled while a query is in progress; loads do not stall it.
// Indexes of ENTRIES or more are dropped. Entries must be loaded before queried.
`timescale 1ns / 1ps
`default_nettype none

module palette_nearest_distinct_distance_unit #(
  parameter int ENTRIES = pndd_pkg::DEF_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_command,
  input  wire  [pndd_pkg::INDEX_W-1:0] in_index,
  input  wire  [pndd_pkg::COMP_W-1:0]  in_red,
  input  wire  [pndd_pkg::COMP_W-1:0]  in_green,
  input  wire  [pndd_pkg::COMP_W-1:0]  in_blue,

  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [pndd_pkg::COMP_W-1:0]  out_color_red,
  output logic [pndd_pkg::COMP_W-1:0]  out_color_green,
  output logic [pndd_pkg::COMP_W-1:0]  out_color_blue,
  output logic [pndd_pkg::QDIST_W-1:0] out_quarter_distance,
  output logic                         out_none_found
);

  import pndd_pkg::*;

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SELF  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  rgb_t              mem [ENTRIES];
  rgb_t              rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  rgb_t              self_r;

  logic              d_v_r;
  logic              x_v_r;
  logic              x_ne_r;
  logic [COMP_W-1:0] x_dr_r, x_dg_r, x_db_r;
  logic              s_v_r;
  logic              s_ne_r;
  logic [DIST_W-1:0] s_sum_r;

  logic              found_r;
  logic [DIST_W-1:0] best_r;

  logic              out_valid_r;
  rgb_t              out_color_r;
  logic [QDIST_W-1:0] out_qdist_r;
  logic              out_none_r;

  logic              in_xfer;
  logic              in_range;
  logic              issue;
  logic              sweep_end;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_index} < (INDEX_W + 1)'(ENTRIES));
  assign issue     = (state_r == S_SWEEP) && (cnt_r < CNT_W'(ENTRIES));
  assign sweep_end = (state_r == S_SWEEP) && !issue && !d_v_r && !x_v_r && !s_v_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = in_index[ADDR_W-1:0];
    end else begin
      rd_addr = cnt_r[ADDR_W-1:0];
    end
  end

  // palette memory, registered read
  always_ff @(posedge clk) begin
    if (in_xfer && in_range && in_command == CMD_LOAD) begin
      mem[in_index[ADDR_W-1:0]] <= '{red: in_red, green: in_green, blue: in_blue};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_range && in_command == CMD_QUERY) begin
          state_nxt = S_SELF;
        end
      end
      S_SELF: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
      end
      S_SWEEP: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (sweep_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // distance pipeline: read, differences, squares and sum, running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r   <= 1'b0;
      x_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      d_v_r <= issue;
      x_v_r <= d_v_r;
      s_v_r <= x_v_r;
      if (state_r == S_SELF) begin
        found_r <= 1'b0;
      end else if (s_v_r && s_ne_r && (!found_r || s_sum_r < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SELF) begin
      self_r <= rd_data_r;
    end
    x_ne_r  <= (rd_data_r != self_r);
    x_dr_r  <= abs_diff(rd_data_r.red, self_r.red);
    x_dg_r  <= abs_diff(rd_data_r.green, self_r.green);
    x_db_r  <= abs_diff(rd_data_r.blue, self_r.blue);
    s_ne_r  <= x_ne_r;
    s_sum_r <= DIST_W'(x_dr_r) * DIST_W'(x_dr_r) + DIST_W'(x_dg_r) * DIST_W'(x_dg_r)
             + DIST_W'(x_db_r) * DIST_W'(x_db_r);
    if (s_v_r && s_ne_r && (!found_r || s_sum_r < best_r)) begin
      best_r <= s_sum_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_color_r <= self_r;
      out_none_r  <= !found_r;
      out_qdist_r <= found_r ? best_r[DIST_W-1:2] : NONE_DISTANCE;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_color_red        = out_color_r.red;
  assign out_color_green      = out_color_r.green;
  assign out_color_blue       = out_color_r.blue;
  assign out_quarter_distance = out_qdist_r;
  assign out_none_found       = out_none_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES))
    else $error("sweep counter beyond palette size");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (d_v_r || x_v_r || s_v_r) |-> state_r == S_SWEEP)
    else $error("distance pipeline active outside sweep");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r == S_DONE) |-> best_r != '0)
    else $error("distinct color with zero distance");

  a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && $past(state_r) != S_DONE) |-> $past(state_r) == S_SWEEP)
    else $error("completion reached without sweep");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pndd_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;

  typedef struct {
    rgb_t               color;
    logic [QDIST_W-1:0] qdist;
    logic               none;
  } nearest_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_command = CMD_LOAD;
  logic [INDEX_W-1:0] in_index = '0;
  logic [COMP_W-1:0]  in_red = '0;
  logic [COMP_W-1:0]  in_green = '0;
  logic [COMP_W-1:0]  in_blue = '0;
  logic               out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [COMP_W-1:0]  out_color_red;
  logic [COMP_W-1:0]  out_color_green;
  logic [COMP_W-1:0]  out_color_blue;
  logic [QDIST_W-1:0] out_quarter_distance;
  logic               out_none_found;

  rgb_t            palette_copy [ENTRIES];
  nearest_result_t pending_results [$];
  int              error_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_cycles = 0;

  palette_nearest_distinct_distance_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_index             (in_index),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_color_red        (out_color_red),
    .out_color_green      (out_color_green),
    .out_color_blue       (out_color_blue),
    .out_quarter_distance (out_quarter_distance),
    .out_none_found       (out_none_found)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("palette_nearest_distinct_distance_unit: mismatch");
    $finish;
  end

  function automatic nearest_result_t nearest_distinct(input int unsigned slot);
    nearest_result_t res;
    rgb_t            self_c;
    rgb_t            other_c;
    int              dr, dg, db, sq_dist, best;
    bit              found;
    self_c = palette_copy[slot];
    found = 1'b0;
    best = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      other_c = palette_copy[k];
      if (other_c != self_c) begin
        dr = int'(self_c.red) - int'(other_c.red);
        dg = int'(self_c.green) - int'(other_c.green);
        db = int'(self_c.blue) - int'(other_c.blue);
        sq_dist = dr * dr + dg * dg + db * db;
        if (!found || sq_dist < best) begin
          best = sq_dist;
          found = 1'b1;
        end
      end
    end
    res.color = self_c;
    res.qdist = found ? QDIST_W'(best / 4) : NONE_DISTANCE;
    res.none = !found;
    return res;
  endfunction

  // update the palette copy and queue what an accepted transfer will return
  task automatic track_transfer(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input rgb_t c);
    if (idx < ENTRIES) begin
      if (cmd == CMD_LOAD) begin
        palette_copy[idx] = c;
      end else begin
        pending_results.insert(pending_results.size(), nearest_distinct(idx));
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx, input rgb_t c);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_index <= idx;
    in_red <= c.red;
    in_green <= c.green;
    in_blue <= c.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_transfer(cmd, idx, c);
  endtask

  task automatic wait_results_done(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic rgb_t make_rgb(input int r, input int g, input int b);
    rgb_t c;
    c.red = COMP_W'(r);
    c.green = COMP_W'(g);
    c.blue = COMP_W'(b);
    return c;
  endfunction

  function automatic rgb_t pick_color();
    rgb_t c;
    case ($urandom_range(3))
      0: c = rgb_t'($urandom);
      1: begin
        // close to a color already present, for small distances
        c = palette_copy[$urandom_range(ENTRIES - 1)];
        c.red = c.red + COMP_W'($urandom_range(3));
        c.green = c.green + COMP_W'($urandom_range(3));
        c.blue = c.blue + COMP_W'($urandom_range(3));
      end
      2: c = palette_copy[$urandom_range(ENTRIES - 1)];
      default: c = make_rgb($urandom_range(1) * 255, $urandom_range(1) * 255,
                            $urandom_range(1) * 255);
    endcase
    return c;
  endfunction

  task automatic test_uniform_palette();
    rgb_t white;
    white = make_rgb(255, 255, 255);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < ENTRIES; k++) send_item(CMD_LOAD, INDEX_W'(k), white);
    // out of range loads are dropped
    send_item(CMD_LOAD, INDEX_W'(ENTRIES), make_rgb(0, 0, 0));
    send_item(CMD_LOAD, 8'hFF, make_rgb(0, 0, 0));
    send_item(CMD_QUERY, 8'd0, make_rgb(0, 0, 0));
    send_item(CMD_QUERY, INDEX_W'(ENTRIES - 1), make_rgb(0, 0, 0));
    send_item(CMD_QUERY, INDEX_W'(ENTRIES), make_rgb(0, 0, 0));
    send_item(CMD_QUERY, 8'hFF, make_rgb(0, 0, 0));
    send_item(CMD_QUERY, 8'd100, make_rgb(0, 0, 0));
    wait_results_done(4);
  endtask

  task automatic test_extreme_distances();
    rgb_t blank;
    blank = make_rgb(0, 0, 0);
    send_item(CMD_LOAD, 8'd7, make_rgb(0, 0, 0));
    send_item(CMD_QUERY, 8'd7, blank);
    send_item(CMD_QUERY, 8'd0, blank);
    send_item(CMD_LOAD, 8'd8, make_rgb(0, 0, 1));
    send_item(CMD_QUERY, 8'd7, blank);
    send_item(CMD_QUERY, 8'd8, blank);
    send_item(CMD_LOAD, 8'd8, make_rgb(255, 255, 255));
    send_item(CMD_LOAD, 8'd9, make_rgb(0, 2, 0));
    send_item(CMD_QUERY, 8'd7, blank);
    send_item(CMD_QUERY, 8'd9, blank);
    send_item(CMD_LOAD, 8'd10, make_rgb(255, 0, 255));
    send_item(CMD_QUERY, 8'd10, blank);
    send_item(CMD_QUERY, INDEX_W'(ENTRIES - 1), blank);
    wait_results_done(4);
  endtask

  task automatic run_mixed_traffic(input int count, input int idle_pct, input int stall_pct);
    int roll;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_item(1'($urandom_range(1)), INDEX_W'($urandom_range(255, ENTRIES)),
                  rgb_t'($urandom));
      end else if (roll < 45) begin
        send_item(CMD_QUERY, INDEX_W'($urandom_range(ENTRIES - 1)), rgb_t'($urandom));
      end else begin
        send_item(CMD_LOAD, INDEX_W'($urandom_range(ENTRIES - 1)), pick_color());
      end
    end
    wait_results_done(4);
  endtask

  task automatic test_mixed_traffic();
    run_mixed_traffic(140, 0, 0);
    run_mixed_traffic(140, 62, 0);
    run_mixed_traffic(140, 0, 62);
    run_mixed_traffic(140, 35, 35);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 2500;
    for (int n = 0; n < 5; n++) begin
      send_item(CMD_QUERY, INDEX_W'($urandom_range(ENTRIES - 1)), rgb_t'($urandom));
      send_item(CMD_LOAD, INDEX_W'($urandom_range(ENTRIES - 1)), pick_color());
    end
    wait_results_done(4);
  endtask

  // receiver side: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [QDIST_W-1:0] want_v,
                             input logic [QDIST_W-1:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    nearest_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result transfer expected none actual %0d", $time,
                 out_quarter_distance);
      end else begin
        want = pending_results.pop_front();
        check_field("color_red", QDIST_W'(want.color.red), QDIST_W'(out_color_red));
        check_field("color_green", QDIST_W'(want.color.green), QDIST_W'(out_color_green));
        check_field("color_blue", QDIST_W'(want.color.blue), QDIST_W'(out_color_blue));
        check_field("quarter_distance", want.qdist, out_quarter_distance);
        check_field("none_found", QDIST_W'(want.none), QDIST_W'(out_none_found));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_uniform_palette();
    test_extreme_distances();
    test_mixed_traffic();
    test_backpressure();
    wait_results_done(ENTRIES + 16);
    if (error_count == 0) begin
      $display("palette_nearest_distinct_distance_unit: match");
    end else begin
      $display("palette_nearest_distinct_distance_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pndd_pkg.sv
src/palette_nearest_distinct_distance_unit.sv
dv/tb_top.sv
